// File: rtl/chh_pkg.sv
// Shared constants, codes and types of the coincidence hit histogram.
package chh_pkg;

  // Histogram geometry and count width
  localparam int PLANE_BINS  = 120;
  localparam int DIFF_BINS   = 240;
  localparam int COUNT_BITS  = 32;

  // Offset that centers the difference histogram, tenths of a bin
  localparam int DIFF_OFFSET = 1195;

  // Position and bin arithmetic widths
  localparam int POS_W  = 12;
  localparam int MAG_W  = POS_W + 1;
  localparam int SUM_W  = POS_W + 2;
  localparam int BIN_W  = 11;  // quotients up to 819, limits up to 240

  // Store depths and address widths
  localparam int PLANE_DEPTH = PLANE_BINS * PLANE_BINS;
  localparam int DIFF_DEPTH  = DIFF_BINS * DIFF_BINS;
  localparam int PLANE_AW    = $clog2(PLANE_DEPTH);
  localparam int DIFF_AW     = $clog2(DIFF_DEPTH);
  localparam int CLR_DEPTH   = (PLANE_DEPTH > DIFF_DEPTH) ? PLANE_DEPTH : DIFF_DEPTH;
  localparam int CLR_W       = $clog2(CLR_DEPTH + 1);

  // Input transaction layout
  localparam int IN_DATA_W  = 72;
  localparam int IN_V0_BIT  = 0;
  localparam int IN_X0_LSB  = 1;
  localparam int IN_Y0_LSB  = 13;
  localparam int IN_V1_BIT  = 25;
  localparam int IN_X1_LSB  = 26;
  localparam int IN_Y1_LSB  = 38;
  localparam int IN_IMG_LSB = 50;
  localparam int IN_COL_LSB = 52;
  localparam int IN_ROW_LSB = 60;

  // Output transaction layout
  localparam int OUT_W        = 32;
  localparam int OUT_DATA_W   = 72;
  localparam int OUT_BIN_LSB  = 0;
  localparam int OUT_PEAK_LSB = 32;
  localparam int OUT_UPD_LSB  = 64;
  localparam int OUT_OOR_BIT  = 66;
  localparam int OUT_USED_W   = 67;

  // Action and image codes
  localparam logic       ACT_ACCUM  = 1'b0;
  localparam logic       ACT_READ   = 1'b1;
  localparam logic [1:0] IMG_PLANE0 = 2'd0;
  localparam logic [1:0] IMG_PLANE1 = 2'd1;
  localparam logic [1:0] IMG_DIFF   = 2'd2;

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_BIN,
    S_ADDR,
    S_UPD,
    S_OUT
  } chh_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear;
    logic load_in;
    logic calc_bin;
    logic issue_rd;
    logic update;
    logic load_out;
  } chh_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
  } chh_sts_t;

endpackage

// File: rtl/chh_ctrl.sv
// Controller state machine: clearing pass, item sequencing, output handshake.
module chh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              out_tready,
  input  chh_pkg::chh_sts_t sts,
  output logic              in_tready,
  output logic              out_tvalid,
  output chh_pkg::chh_cmd_t cmd
);
  import chh_pkg::*;

  chh_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (in_tvalid) state_nxt = S_BIN;
      S_BIN:   state_nxt = S_ADDR;
      S_ADDR:  state_nxt = S_UPD;
      S_UPD:   state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Outputs and commands
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_CLEAR: cmd.clear = 1'b1;
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
      end
      S_BIN:   cmd.calc_bin = 1'b1;
      S_ADDR:  cmd.issue_rd = 1'b1;
      S_UPD:   cmd.update   = 1'b1;
      S_OUT:   cmd.load_out = out_free;
      default: cmd = '0;
    endcase
  end

  // Track the output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// File: rtl/chh_datapath.sv
// Datapath: binning, histogram memories, saturating update, peaks, result register.
module chh_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  chh_pkg::chh_cmd_t            cmd,
  input  logic [chh_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                         in_tuser,
  output chh_pkg::chh_sts_t            sts,
  output logic [chh_pkg::OUT_DATA_W-1:0] out_tdata
);
  import chh_pkg::*;

  localparam int PROD_W = MAG_W + 13;
  localparam int DIV_K  = 6554;   // 2^16 / 10, rounded up
  localparam int DIV_SH = 16;

  typedef struct packed {
    logic             ok;
    logic [BIN_W-1:0] bin;
  } bin_res_t;

  // Divide a nonnegative value by ten through the reciprocal
  function automatic logic [BIN_W-1:0] div10(input logic [MAG_W-1:0] v);
    logic [PROD_W-1:0] p;
    p = PROD_W'(v) * PROD_W'(DIV_K);
    return BIN_W'(p[PROD_W-1:DIV_SH]);
  endfunction

  // Plane bin with truncation toward zero; small negatives land in bin zero
  function automatic bin_res_t plane_bin(input logic [POS_W-1:0] x);
    bin_res_t         r;
    logic [MAG_W-1:0] mag;
    logic [BIN_W-1:0] q;
    mag = x[POS_W-1] ? (MAG_W'(0) - {x[POS_W-1], x}) : {1'b0, x};
    q   = div10(mag);
    if (x[POS_W-1]) begin
      r.ok  = (mag < MAG_W'(10));
      r.bin = '0;
    end else begin
      r.ok  = (q < BIN_W'(PLANE_BINS));
      r.bin = q;
    end
    return r;
  endfunction

  // Difference bin: offset sum must be positive and the bin in range
  function automatic bin_res_t diff_bin(input logic [POS_W-1:0] a,
                                        input logic [POS_W-1:0] b);
    bin_res_t         r;
    logic [SUM_W-1:0] s;
    s = {{(SUM_W-POS_W){a[POS_W-1]}}, a} - {{(SUM_W-POS_W){b[POS_W-1]}}, b}
        + SUM_W'(DIFF_OFFSET);
    r.bin = div10(s[MAG_W-1:0]);
    r.ok  = !s[SUM_W-1] && (s != '0) && (r.bin < BIN_W'(DIFF_BINS));
    return r;
  endfunction

  function automatic count_t sat_inc(input count_t c);
    return (c == '1) ? c : c + COUNT_BITS'(1);
  endfunction

  function automatic logic [OUT_W-1:0] to_out(input count_t c);
    logic [COUNT_BITS+OUT_W-1:0] w;
    w = {{OUT_W{1'b0}}, c};
    return w[OUT_W-1:0];
  endfunction

  // Captured transaction
  logic             act_r, v0_r, v1_r;
  logic [POS_W-1:0] x0_r, y0_r, x1_r, y1_r;
  logic [1:0]       img_r;
  logic [7:0]       col_r, row_r;

  // Bin stage
  logic [BIN_W-1:0] b0x_r, b0y_r, b1x_r, b1y_r, bdx_r, bdy_r;
  logic             ok0_r, ok1_r, okd_r, rd_ok_r;
  bin_res_t         p0x, p0y, p1x, p1y, dx, dy;
  logic [BIN_W-1:0] col_w, row_w;

  // Address and read stage
  logic [PLANE_AW-1:0] a0, a1, a0_r, a1_r;
  logic [DIFF_AW-1:0]  ad, ad_r;
  count_t              rd0_r, rd1_r, rdd_r;

  // Memories
  count_t mem0 [PLANE_DEPTH];
  count_t mem1 [PLANE_DEPTH];
  count_t memd [DIFF_DEPTH];

  // Update stage
  count_t n0, n1, nd;
  count_t pk0_r, pk1_r, pkd_r, pk0_nxt, pk1_nxt, pkd_nxt;
  logic                we0, we1, wed;
  logic [PLANE_AW-1:0] wa0, wa1;
  logic [DIFF_AW-1:0]  wad;
  count_t              wd0, wd1, wdd;

  // Result
  count_t     res_bin_r, res_peak_r, res_bin_nxt, res_peak_nxt;
  logic [1:0] res_upd_r, res_upd_nxt;
  logic       res_oor_r, res_oor_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [CLR_W-1:0] clr_cnt_r;

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r <= in_tuser;
      v0_r  <= in_tdata[IN_V0_BIT];
      x0_r  <= in_tdata[IN_X0_LSB +: POS_W];
      y0_r  <= in_tdata[IN_Y0_LSB +: POS_W];
      v1_r  <= in_tdata[IN_V1_BIT];
      x1_r  <= in_tdata[IN_X1_LSB +: POS_W];
      y1_r  <= in_tdata[IN_Y1_LSB +: POS_W];
      img_r <= in_tdata[IN_IMG_LSB +: 2];
      col_r <= in_tdata[IN_COL_LSB +: 8];
      row_r <= in_tdata[IN_ROW_LSB +: 8];
    end
  end

  // Bin the hits, or take the read address
  always_comb begin
    p0x   = plane_bin(x0_r);
    p0y   = plane_bin(y0_r);
    p1x   = plane_bin(x1_r);
    p1y   = plane_bin(y1_r);
    dx    = diff_bin(x0_r, x1_r);
    dy    = diff_bin(y0_r, y1_r);
    col_w = BIN_W'(col_r);
    row_w = BIN_W'(row_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_bin) begin
      if (act_r == ACT_READ) begin
        b0x_r <= col_w;
        b0y_r <= row_w;
        b1x_r <= col_w;
        b1y_r <= row_w;
        bdx_r <= col_w;
        bdy_r <= row_w;
        ok0_r <= 1'b0;
        ok1_r <= 1'b0;
        okd_r <= 1'b0;
      end else begin
        b0x_r <= p0x.bin;
        b0y_r <= p0y.bin;
        b1x_r <= p1x.bin;
        b1y_r <= p1y.bin;
        bdx_r <= dx.bin;
        bdy_r <= dy.bin;
        ok0_r <= v0_r && p0x.ok && p0y.ok;
        ok1_r <= v1_r && p1x.ok && p1y.ok;
        okd_r <= v0_r && v1_r && dx.ok && dy.ok;
      end
      case (img_r)
        IMG_PLANE0, IMG_PLANE1:
          rd_ok_r <= (col_w < BIN_W'(PLANE_BINS)) && (row_w < BIN_W'(PLANE_BINS));
        IMG_DIFF:
          rd_ok_r <= (col_w < BIN_W'(DIFF_BINS)) && (row_w < BIN_W'(DIFF_BINS));
        default: rd_ok_r <= 1'b0;
      endcase
    end
  end

  // Form row-major addresses
  always_comb begin
    a0 = PLANE_AW'(PLANE_AW'(b0y_r) * PLANE_AW'(PLANE_BINS) + PLANE_AW'(b0x_r));
    a1 = PLANE_AW'(PLANE_AW'(b1y_r) * PLANE_AW'(PLANE_BINS) + PLANE_AW'(b1x_r));
    ad = DIFF_AW'(DIFF_AW'(bdy_r) * DIFF_AW'(DIFF_BINS) + DIFF_AW'(bdx_r));
  end

  always_ff @(posedge clk) begin
    if (cmd.issue_rd) begin
      a0_r <= a0;
      a1_r <= a1;
      ad_r <= ad;
    end
  end

  // Saturating increments and write ports
  always_comb begin
    n0  = sat_inc(rd0_r);
    n1  = sat_inc(rd1_r);
    nd  = sat_inc(rdd_r);
    we0 = cmd.clear ? (clr_cnt_r < CLR_W'(PLANE_DEPTH)) : (cmd.update && ok0_r);
    we1 = cmd.clear ? (clr_cnt_r < CLR_W'(PLANE_DEPTH)) : (cmd.update && ok1_r);
    wed = cmd.clear ? (clr_cnt_r < CLR_W'(DIFF_DEPTH))  : (cmd.update && okd_r);
    wa0 = cmd.clear ? clr_cnt_r[PLANE_AW-1:0] : a0_r;
    wa1 = cmd.clear ? clr_cnt_r[PLANE_AW-1:0] : a1_r;
    wad = cmd.clear ? clr_cnt_r[DIFF_AW-1:0]  : ad_r;
    wd0 = cmd.clear ? '0 : n0;
    wd1 = cmd.clear ? '0 : n1;
    wdd = cmd.clear ? '0 : nd;
  end

  // Histogram memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (we0) mem0[wa0] <= wd0;
    if (cmd.issue_rd) rd0_r <= mem0[a0];
  end

  always_ff @(posedge clk) begin
    if (we1) mem1[wa1] <= wd1;
    if (cmd.issue_rd) rd1_r <= mem1[a1];
  end

  always_ff @(posedge clk) begin
    if (wed) memd[wad] <= wdd;
    if (cmd.issue_rd) rdd_r <= memd[ad];
  end

  // Advance the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + CLR_W'(1);
    end
  end

  assign sts.clr_last = (clr_cnt_r == CLR_W'(CLR_DEPTH - 1));

  // Peaks and result
  always_comb begin
    pk0_nxt = (ok0_r && (n0 > pk0_r)) ? n0 : pk0_r;
    pk1_nxt = (ok1_r && (n1 > pk1_r)) ? n1 : pk1_r;
    pkd_nxt = (okd_r && (nd > pkd_r)) ? nd : pkd_r;
    res_bin_nxt  = '0;
    res_peak_nxt = '0;
    res_upd_nxt  = '0;
    res_oor_nxt  = 1'b0;
    if (act_r == ACT_ACCUM) begin
      res_peak_nxt = pkd_nxt;
      res_upd_nxt  = {1'b0, ok0_r} + {1'b0, ok1_r} + {1'b0, okd_r};
    end else begin
      res_oor_nxt = !rd_ok_r;
      case (img_r)
        IMG_PLANE0: begin
          res_peak_nxt = pk0_r;
          res_bin_nxt  = rd_ok_r ? rd0_r : '0;
        end
        IMG_PLANE1: begin
          res_peak_nxt = pk1_r;
          res_bin_nxt  = rd_ok_r ? rd1_r : '0;
        end
        IMG_DIFF: begin
          res_peak_nxt = pkd_r;
          res_bin_nxt  = rd_ok_r ? rdd_r : '0;
        end
        default: res_oor_nxt = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pk0_r <= '0;
      pk1_r <= '0;
      pkd_r <= '0;
    end else if (cmd.update) begin
      pk0_r <= pk0_nxt;
      pk1_r <= pk1_nxt;
      pkd_r <= pkd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      res_bin_r  <= res_bin_nxt;
      res_peak_r <= res_peak_nxt;
      res_upd_r  <= res_upd_nxt;
      res_oor_r  <= res_oor_nxt;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {{(OUT_DATA_W-OUT_USED_W){1'b0}}, res_oor_r, res_upd_r,
                     to_out(res_peak_r), to_out(res_bin_r)};
    end
  end

  assign out_tdata = out_data_r;

endmodule

// File: rtl/coincidence_hit_histogram.sv
// Top level of the coincidence hit histogram: controller plus datapath.
//
// channel   direction  handshake             payload
// in_       slave      in_tvalid/in_tready   tdata: hit fields and read address;
//                                            tuser: action
// out_      master     out_tvalid/out_tready tdata: bin, peak, bins updated,
//                                            read out of range
//
// An item passes through one controller state per step: capture, bin
// (reciprocal divide by ten), address and memory read, saturating update
// and write-back, output load. After reset a clearing pass zeroes every
// bin, one address per cycle, over all 57600 addresses with in_tready low.
// A stalled result holds in the output register; the next item is still
// accepted and waits before output load.
module coincidence_hit_histogram (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // hit0_valid, hit0_x, hit0_y, hit1_valid, hit1_x, hit1_y, read_image,
  // read_col, read_row
  input  logic [chh_pkg::IN_DATA_W-1:0]  in_tdata,
  // action
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // bin_count, peak_count, bins_updated, read_out_of_range
  output logic [chh_pkg::OUT_DATA_W-1:0] out_tdata
);
  import chh_pkg::*;

  chh_cmd_t cmd;
  chh_sts_t sts;

  chh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  chh_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule

// File: rtl/chh_checker.sv
// Port checker for the coincidence hit histogram and its bind.
module chh_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [chh_pkg::OUT_DATA_W-1:0] out_tdata
);
  import chh_pkg::*;

  // Ready is low right after reset, while the clearing pass runs
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_tready)
    else $error("input ready right after reset");

  // One item at a time: ready drops after each accepted transaction
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item accepted back to back");

  // An out-of-range read reports an empty bin and no updates
  a_oor_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[OUT_OOR_BIT]) |->
      (out_tdata[OUT_BIN_LSB +: OUT_W] == '0) && (out_tdata[OUT_UPD_LSB +: 2] == 2'd0))
    else $error("out-of-range read with nonzero bin or updates");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind coincidence_hit_histogram chh_checker u_chh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: sim/coincidence_hit_histogram_tb.sv
// Self-checking testbench for the coincidence hit histogram: driver, monitor and bin predictor.
`timescale 1ns / 1ps

module coincidence_hit_histogram_tb;
  import chh_pkg::*;

  // Image code with no histogram behind it
  localparam logic [1:0] IMG_NONE = 2'd3;

  localparam int RANDOM_ITEMS  = 1100;
  localparam int STALL_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic                    action;
    logic                    v0;
    logic signed [POS_W-1:0] x0;
    logic signed [POS_W-1:0] y0;
    logic                    v1;
    logic signed [POS_W-1:0] x1;
    logic signed [POS_W-1:0] y1;
    logic [1:0]              img;
    logic [7:0]              col;
    logic [7:0]              row;
    bit                      drain;  // wait for all results before sending
  } hit_item_t;

  // Same layout as the low bits of out_tdata
  typedef struct packed {
    logic            oor;
    logic [1:0]      upd;
    logic [OUT_W-1:0] peak;
    logic [OUT_W-1:0] bin;
  } hist_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Predictor state: sparse bin counts keyed by image, row and column
  count_t       hist_count [int];
  count_t       hist_peak [3] = '{default: '0};

  hit_item_t    hit_items[$];
  hist_result_t due_results[$];
  hit_item_t    cur_item;
  hist_result_t want, got;

  int total_items = 0;
  int sent_cnt    = 0;
  int res_cnt     = 0;
  int accum_cnt   = 0;
  int read_cnt    = 0;
  int oor_cnt     = 0;
  int err_cnt     = 0;
  int hold_cnt    = 0;
  int stall_cnt   = 0;
  int quiet_cnt   = 0;

  coincidence_hit_histogram u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #4 clk = ~clk;

  function automatic int bin_key(int img, int row, int col);
    return img * 65536 + row * 256 + col;
  endfunction

  function automatic count_t bin_value(int img, int row, int col);
    int key;
    key = bin_key(img, row, col);
    return hist_count.exists(key) ? hist_count[key] : '0;
  endfunction

  // Count one hit with saturation and raise the peak
  function automatic void bump_bin(int img, int row, int col);
    count_t c;
    c = bin_value(img, row, col);
    if (c != '1) c = c + COUNT_BITS'(1);
    hist_count[bin_key(img, row, col)] = c;
    if (c > hist_peak[img]) hist_peak[img] = c;
  endfunction

  // Apply one transaction to the histograms and return what the block reports
  function automatic hist_result_t histogram_step(hit_item_t it);
    hist_result_t r;
    int   px[2], py[2];
    logic hv[2];
    int   sx, sy;
    r = '0;
    if (it.action == ACT_ACCUM) begin
      hv[0] = it.v0;
      hv[1] = it.v1;
      px[0] = int'(it.x0);
      py[0] = int'(it.y0);
      px[1] = int'(it.x1);
      py[1] = int'(it.y1);
      // plane bins truncate toward zero
      for (int p = 0; p < 2; p++) begin
        if (hv[p] && px[p] / 10 >= 0 && py[p] / 10 >= 0 &&
            px[p] / 10 < PLANE_BINS && py[p] / 10 < PLANE_BINS) begin
          bump_bin(p, py[p] / 10, px[p] / 10);
          r.upd = r.upd + 2'd1;
        end
      end
      if (hv[0] && hv[1]) begin
        sx = px[0] - px[1] + DIFF_OFFSET;
        sy = py[0] - py[1] + DIFF_OFFSET;
        if (sx > 0 && sy > 0 && sx / 10 < DIFF_BINS && sy / 10 < DIFF_BINS) begin
          bump_bin(int'(IMG_DIFF), sy / 10, sx / 10);
          r.upd = r.upd + 2'd1;
        end
      end
      r.peak = hist_peak[IMG_DIFF];
    end else if (it.img == IMG_PLANE0 || it.img == IMG_PLANE1) begin
      r.peak = hist_peak[it.img];
      if (it.col < PLANE_BINS && it.row < PLANE_BINS)
        r.bin = bin_value(int'(it.img), int'(it.row), int'(it.col));
      else r.oor = 1'b1;
    end else if (it.img == IMG_DIFF) begin
      r.peak = hist_peak[IMG_DIFF];
      if (it.col < DIFF_BINS && it.row < DIFF_BINS)
        r.bin = bin_value(int'(IMG_DIFF), int'(it.row), int'(it.col));
      else r.oor = 1'b1;
    end else begin
      r.oor = 1'b1;
    end
    return r;
  endfunction

  // Accumulate transaction; read fields carry junk
  function automatic hit_item_t make_accum(bit v0, int x0, int y0, bit v1, int x1, int y1);
    hit_item_t it;
    it.action = ACT_ACCUM;
    it.v0     = v0;
    it.x0     = POS_W'(x0);
    it.y0     = POS_W'(y0);
    it.v1     = v1;
    it.x1     = POS_W'(x1);
    it.y1     = POS_W'(y1);
    it.img    = 2'($urandom_range(0, 3));
    it.col    = 8'($urandom_range(0, 255));
    it.row    = 8'($urandom_range(0, 255));
    it.drain  = 1'b0;
    return it;
  endfunction

  // Read transaction; hit fields carry junk
  function automatic hit_item_t make_read(logic [1:0] img, int col, int row);
    hit_item_t it;
    it        = make_accum(1'($urandom_range(0, 1)), $urandom, $urandom,
                           1'($urandom_range(0, 1)), $urandom, $urandom);
    it.action = ACT_READ;
    it.img    = img;
    it.col    = 8'(col);
    it.row    = 8'(row);
    return it;
  endfunction

  // Positions clustered on a few bins so counts and peaks climb
  function automatic int hot_pos();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return -int'($urandom_range(1, 9));
    if (r == 1) return int'($urandom_range(1150, 1209));
    if (r == 2) return int'($urandom_range(0, 1199));
    return int'($urandom_range(0, 39));
  endfunction

  // Read address aimed at bins the hot positions fill
  function automatic int read_coord(logic [1:0] img);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return int'($urandom_range(0, 255));
    if (img == IMG_DIFF) return int'($urandom_range(114, 124));
    if (r < 3) return int'($urandom_range(115, 121));
    return int'($urandom_range(0, 3));
  endfunction

  // Idle length: mostly short, a few long, and stretches with none
  function automatic int pick_idle(int count);
    int r;
    if ((count / 128) % 4 == 2) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: record the accepted transaction, then present the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        due_results.push_back(histogram_step(cur_item));
        if (cur_item.action == ACT_ACCUM) accum_cnt++;
        else read_cnt++;
        sent_cnt++;
      end
      if (!in_tvalid || in_tready) begin
        if (hold_cnt > 0) begin
          hold_cnt--;
          in_tvalid <= 1'b0;
        end else if (hit_items.size() > 0 &&
                     !(hit_items[0].drain && due_results.size() > 0)) begin
          cur_item = hit_items.pop_front();
          in_tdata <= {4'b0, cur_item.row, cur_item.col, cur_item.img,
                       cur_item.y1, cur_item.x1, cur_item.v1,
                       cur_item.y0, cur_item.x0, cur_item.v0};
          in_tuser  <= cur_item.action;
          in_tvalid <= 1'b1;
          hold_cnt = pick_idle(sent_cnt);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[OUT_USED_W-1:0];
        if (got.oor) oor_cnt++;
        if (due_results.size() == 0) begin
          $error("unexpected result: out_tdata %h", out_tdata);
          err_cnt++;
        end else begin
          want = due_results.pop_front();
          if (got.bin !== want.bin) begin
            $error("bin_count: expected %0d, got %0d", want.bin, got.bin);
            err_cnt++;
          end
          if (got.peak !== want.peak) begin
            $error("peak_count: expected %0d, got %0d", want.peak, got.peak);
            err_cnt++;
          end
          if (got.upd !== want.upd) begin
            $error("bins_updated: expected %0d, got %0d", want.upd, got.upd);
            err_cnt++;
          end
          if (got.oor !== want.oor) begin
            $error("read_out_of_range: expected %0d, got %0d", want.oor, got.oor);
            err_cnt++;
          end
        end
        res_cnt++;
        if (stall_cnt == 0) stall_cnt = pick_idle(res_cnt + 64);
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  initial begin
    hit_item_t it;
    int        r, x0, y0, x1, y1;
    logic [1:0] img;

    // Directed: bin edges, truncation, difference window limits
    hit_items.push_back(make_accum(1, 0, 0, 1, 0, 0));
    hit_items.push_back(make_accum(1, -9, -1, 0, 77, -77));
    hit_items.push_back(make_accum(1, -10, 5, 1, 5, -10));
    hit_items.push_back(make_accum(1, 1199, 1199, 1, 1199, 1199));
    hit_items.push_back(make_accum(1, 1200, 0, 1, 0, 1200));
    hit_items.push_back(make_accum(1, -2048, -2048, 1, 2047, 2047));
    hit_items.push_back(make_accum(1, 2047, 2047, 1, -2048, -2048));
    hit_items.push_back(make_accum(1, 0, 0, 1, 1195, 0));
    hit_items.push_back(make_accum(1, 0, 0, 1, 1194, 0));
    hit_items.push_back(make_accum(1, 1204, 0, 1, 0, 0));
    hit_items.push_back(make_accum(1, 1205, 0, 1, 0, 0));
    hit_items.push_back(make_accum(0, 2047, -2048, 1, 15, 25));
    hit_items.push_back(make_accum(0, -1, -1, 0, -1, -1));
    hit_items.push_back(make_accum(1, -2048, 2047, 0, 0, 0));
    hit_items.push_back(make_read(IMG_PLANE0, 0, 0));
    hit_items.push_back(make_read(IMG_PLANE1, 119, 119));
    hit_items.push_back(make_read(IMG_DIFF, 119, 119));
    hit_items.push_back(make_read(IMG_DIFF, 0, 119));
    hit_items.push_back(make_read(IMG_DIFF, 239, 239));
    hit_items.push_back(make_read(IMG_PLANE0, 120, 0));
    hit_items.push_back(make_read(IMG_PLANE1, 0, 255));
    hit_items.push_back(make_read(IMG_DIFF, 240, 0));
    hit_items.push_back(make_read(IMG_DIFF, 255, 255));
    hit_items.push_back(make_read(IMG_NONE, 0, 0));
    hit_items.push_back(make_read(IMG_NONE, 255, 255));

    // Random: mostly clustered hits and aimed reads, some raw noise
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        x0 = hot_pos();
        y0 = hot_pos();
        if ($urandom_range(0, 2) == 0) begin
          x1 = x0 + int'($urandom_range(0, 40)) - 20;
          y1 = y0 + int'($urandom_range(0, 40)) - 20;
        end else begin
          x1 = hot_pos();
          y1 = hot_pos();
        end
        it = make_accum($urandom_range(0, 99) < 85, x0, y0,
                        $urandom_range(0, 99) < 85, x1, y1);
      end else if (r < 65) begin
        it = make_accum(1'($urandom_range(0, 1)), $urandom, $urandom,
                        1'($urandom_range(0, 1)), $urandom, $urandom);
      end else if (r < 95) begin
        img = ($urandom_range(0, 19) == 0) ? IMG_NONE : 2'($urandom_range(0, 2));
        it  = make_read(img, read_coord(img), read_coord(img));
      end else begin
        it = make_read(2'($urandom_range(0, 3)), int'($urandom_range(0, 255)),
                       int'($urandom_range(0, 255)));
      end
      it.drain = (i % 350 == 0);
      hit_items.push_back(it);
    end
    total_items = hit_items.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every transaction and its result, then let the pipe settle
    while (sent_cnt < total_items || due_results.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d transactions (%0d accumulate, %0d read), checked %0d results",
             sent_cnt, accum_cnt, read_cnt, res_cnt);
    $display("Out-of-range reads %0d; peaks plane0 %0d plane1 %0d difference %0d",
             oor_cnt, hist_peak[IMG_PLANE0], hist_peak[IMG_PLANE1], hist_peak[IMG_DIFF]);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/chh_pkg.sv
rtl/chh_ctrl.sv
rtl/chh_datapath.sv
rtl/coincidence_hit_histogram.sv
rtl/chh_checker.sv
sim/coincidence_hit_histogram_tb.sv
